@@ hw/rtl/lkh_pkg.sv @@
`timescale 1ns / 1ps

package lkh_pkg;

  // Input actions
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_KEY   = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Keymap entry types
  localparam logic [2:0] TYPE_NONE   = 3'd0;
  localparam logic [2:0] TYPE_HID    = 3'd1;
  localparam logic [2:0] TYPE_MOD    = 3'd2;
  localparam logic [2:0] TYPE_SWITCH = 3'd3;

  // Keymap entry: type in the upper three bits, data byte below
  localparam int ENTRY_W    = 11;
  localparam int MAP_BITS   = 256;
  localparam int MAP_BYTES  = 32;
  localparam int MAX_SLOTS  = 6;
  localparam logic [7:0] MOD_BIT_MAX = 8'd7;
  localparam logic [4:0] LAST_BYTE   = 5'd31;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_APPLY,
    ST_START,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
  } scan_ctl_t;

  typedef struct packed {
    logic done;
  } scan_sts_t;

endpackage

@@ hw/rtl/lkh_keymap_ram.sv @@
`timescale 1ns / 1ps

module lkh_keymap_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [lkh_pkg::ENTRY_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [lkh_pkg::ENTRY_W-1:0] rdata
);

  logic [lkh_pkg::ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/lkh_scan.sv @@
`timescale 1ns / 1ps

// Byte-wise sweep of the pressed map: peel the lowest set bit of the current
// byte each cycle, advance to the next byte when it runs empty.
module lkh_scan #(
  parameter int REPORT_SLOTS = 6
) (
  input  logic                               clk,
  input  logic                               rst,
  input  lkh_pkg::scan_ctl_t                 ctl,
  input  logic [lkh_pkg::MAP_BITS-1:0]       pressed_map,
  output lkh_pkg::scan_sts_t                 sts,
  output logic [REPORT_SLOTS-1:0][7:0]       slots
);

  localparam int CW = $clog2(REPORT_SLOTS + 1);

  logic          busy;
  logic          done;
  logic [4:0]    bidx;
  logic [7:0]    work;
  logic [CW-1:0] cnt;
  logic [2:0]    low;
  logic [4:0]    nidx;

  always_comb begin
    low = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (work[i]) begin
        low = 3'(i);
      end
    end
  end

  assign nidx = bidx + 5'd1;
  assign sts.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        bidx <= 5'd0;
        work <= pressed_map[7:0];
        cnt  <= '0;
        slots <= '0;
      end else if (busy) begin
        if (cnt == CW'(REPORT_SLOTS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else if (work != 8'd0) begin
          for (int i = 0; i < REPORT_SLOTS; i++) begin
            if (cnt == CW'(i)) begin
              slots[i] <= {bidx, low};
            end
          end
          cnt  <= cnt + CW'(1);
          work <= work & (work - 8'd1);
        end else if (bidx == lkh_pkg::LAST_BYTE) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          bidx <= nidx;
          work <= pressed_map[{nidx, 3'b000} +: 8];
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt <= CW'(REPORT_SLOTS)))
    else $error("scan count beyond report slots");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("scan done while still busy");
`endif

endmodule

@@ hw/rtl/layered_keymap_hid_report.sv @@
`timescale 1ns / 1ps

// Result: each input transaction yields one report, a keystroke after an extra apply state.
//   The report is built by a byte-wise sweep of the 256-bit pressed map, cut short
//   once REPORT_SLOTS codes are found.
// Items: one at a time. The next is taken the cycle after the result is staged,
//   even while that result waits in the output register.
// Reset: control state clears at once, then the keymap is swept to type none,
//   one entry a cycle, LAYERS * 2**ceil(log2(min(KEYS,256))) entries (2048 default).
module layered_keymap_hid_report #(
  parameter int LAYERS       = 8,
  parameter int KEYS         = 256,
  parameter int REPORT_SLOTS = 6
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  logic [7:0] key_id,
  input  logic [2:0] entry_layer,
  input  logic [2:0] entry_type,
  input  logic [7:0] entry_data,
  input  logic       is_release,
  input  logic [4:0] map_byte_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] modifier_bits,
  output logic [7:0] slot0,
  output logic [7:0] slot1,
  output logic [7:0] slot2,
  output logic [7:0] slot3,
  output logic [7:0] slot4,
  output logic [7:0] slot5,
  output logic [7:0] active_layer,
  output logic [7:0] map_byte
);

  // Key codes are eight bits, so only the first min(KEYS,256) keys are reachable.
  localparam int KEY_SPAN  = (KEYS < 256) ? KEYS : 256;
  localparam int KW        = $clog2(KEY_SPAN);
  localparam int MEM_DEPTH = LAYERS << KW;
  localparam int AW        = $clog2(MEM_DEPTH);

  lkh_pkg::state_t state, state_next;

  // Architectural state
  logic [lkh_pkg::MAP_BITS-1:0] pressed_map;
  logic [7:0]                   modifier_reg;
  logic [7:0]                   layer_reg;
  logic [7:0]                   switch_key;

  // Per-item holding registers
  logic [7:0] key_r;
  logic       rel_r;
  logic       look_ok;
  logic [7:0] map_byte_r;

  // Keymap clearing sweep
  logic [AW-1:0] clr_cnt;

  // Keymap port signals
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [lkh_pkg::ENTRY_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [lkh_pkg::ENTRY_W-1:0] mem_rdata;
  logic [8+KW-1:0]             wr_full;
  logic [8+KW-1:0]             rd_full;

  logic in_acc;
  logic out_free;
  logic wr_ok;
  logic key_ok;

  lkh_pkg::scan_ctl_t scan_ctl;
  lkh_pkg::scan_sts_t scan_sts;
  logic [REPORT_SLOTS-1:0][7:0]       scan_slots;
  logic [lkh_pkg::MAX_SLOTS-1:0][7:0] slot_all;

  logic [2:0] ent_type;
  logic [7:0] ent_data;

  assign in_stall = (state != lkh_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Range checks: writes past the table are dropped, as are lookups of key zero,
  // of a key past the table or from a layer beyond the table.
  assign wr_ok  = (32'(entry_layer) < LAYERS) && (32'(key_id) < KEYS);
  assign key_ok = (key_id != 8'd0) && (32'(layer_reg) < LAYERS)
                  && (32'(key_id) < KEYS);

  // Entry address is {layer, key}; the layer is known to be in range, so the
  // upper bits above AW are zero.
  assign wr_full = {5'd0, entry_layer, key_id[KW-1:0]};
  assign rd_full = {layer_reg, key_id[KW-1:0]};

  always_comb begin
    if (state == lkh_pkg::ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else begin
      mem_we    = in_acc && (action == lkh_pkg::ACT_WRITE) && wr_ok;
      mem_waddr = wr_full[AW-1:0];
      mem_wdata = {entry_type, entry_data};
    end
  end

  assign mem_re = in_acc && (action == lkh_pkg::ACT_KEY) && key_ok;

  lkh_keymap_ram #(
    .DEPTH (MEM_DEPTH),
    .AW    (AW)
  ) u_keymap (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (rd_full[AW-1:0]),
    .rdata (mem_rdata)
  );

  lkh_scan #(
    .REPORT_SLOTS (REPORT_SLOTS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .ctl         (scan_ctl),
    .pressed_map (pressed_map),
    .sts         (scan_sts),
    .slots       (scan_slots)
  );

  assign ent_type = mem_rdata[10:8];
  assign ent_data = mem_rdata[7:0];

  // Report slots past REPORT_SLOTS read as zero.
  always_comb begin
    slot_all = '0;
    for (int i = 0; i < REPORT_SLOTS; i++) begin
      slot_all[i] = scan_slots[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lkh_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: keystrokes pass through ST_APPLY for the keymap read, then every
  // action goes through one sweep of the scanner and waits for the output slot.
  always_comb begin
    state_next     = state;
    scan_ctl.start = 1'b0;
    case (state)
      lkh_pkg::ST_CLEAR: begin
        if (clr_cnt == AW'(MEM_DEPTH - 1)) begin
          state_next = lkh_pkg::ST_IDLE;
        end
      end
      lkh_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_next = (action == lkh_pkg::ACT_KEY) ? lkh_pkg::ST_APPLY
                                                    : lkh_pkg::ST_START;
        end
      end
      lkh_pkg::ST_APPLY: begin
        state_next = lkh_pkg::ST_START;
      end
      lkh_pkg::ST_START: begin
        scan_ctl.start = 1'b1;
        state_next     = lkh_pkg::ST_SCAN;
      end
      lkh_pkg::ST_SCAN: begin
        if (scan_sts.done) begin
          state_next = lkh_pkg::ST_DONE;
        end
      end
      lkh_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = lkh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lkh_pkg::ST_IDLE;
      end
    endcase
  end

  // Clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == lkh_pkg::ST_CLEAR) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // Latch the transaction; a map byte is captured now, before any change.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r      <= key_id;
      rel_r      <= is_release;
      look_ok    <= (action == lkh_pkg::ACT_KEY) && key_ok;
      map_byte_r <= (action == lkh_pkg::ACT_READ)
                    ? pressed_map[{map_byte_index, 3'b000} +: 8] : 8'd0;
    end
  end

  // Apply the looked-up entry to the key state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pressed_map  <= '0;
      modifier_reg <= 8'd0;
      layer_reg    <= 8'd0;
      switch_key   <= 8'd0;
    end else if ((state == lkh_pkg::ST_APPLY) && look_ok
                 && (ent_type != lkh_pkg::TYPE_NONE)) begin
      if ((switch_key == key_r) && (layer_reg != 8'd0)) begin
        // Active switch key: only its release does something, back to layer 0.
        if (rel_r) begin
          layer_reg  <= 8'd0;
          switch_key <= 8'd0;
        end
      end else begin
        case (ent_type)
          lkh_pkg::TYPE_HID: begin
            pressed_map[ent_data] <= !rel_r;
          end
          lkh_pkg::TYPE_MOD: begin
            if (ent_data <= lkh_pkg::MOD_BIT_MAX) begin
              modifier_reg[ent_data[2:0]] <= !rel_r;
            end
          end
          lkh_pkg::TYPE_SWITCH: begin
            if (!rel_r && (layer_reg == 8'd0)) begin
              layer_reg  <= ent_data;
              switch_key <= key_r;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Output register: load the finished report once the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == lkh_pkg::ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == lkh_pkg::ST_DONE) && out_free) begin
      modifier_bits <= modifier_reg;
      slot0         <= slot_all[0];
      slot1         <= slot_all[1];
      slot2         <= slot_all[2];
      slot3         <= slot_all[3];
      slot4         <= slot_all[4];
      slot5         <= slot_all[5];
      active_layer  <= layer_reg;
      map_byte      <= map_byte_r;
    end
  end

`ifndef SYNTHESIS
  a_layer_owner: assert property (@(posedge clk) disable iff (rst)
    (layer_reg != 8'd0) |-> (switch_key != 8'd0))
    else $error("nonzero layer without a switch key");

  a_mod_apply: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (modifier_reg != $past(modifier_reg)))
      |-> ($past(state) == lkh_pkg::ST_APPLY))
    else $error("modifier byte changed outside apply");

  a_slots_sorted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (slot1 != 8'd0)) |-> (slot0 < slot1))
    else $error("report slots out of order");
`endif

endmodule

@@ tb/layered_keymap_hid_report_tb.sv @@
`timescale 1ns / 1ps

module layered_keymap_hid_report_tb;

  // Codes the package leaves out: the spare action and the no-op entry types
  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam logic [2:0] TYPE_ACTION = 3'd4;
  localparam logic [2:0] TYPE_UNDEF  = 3'd7;

  localparam int N_LAYERS  = 8;
  localparam int N_KEYS    = 256;
  localparam int POOL_SIZE = 16;

  // One input transaction, field for field as on the ports
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] key_id;
    logic [2:0] entry_layer;
    logic [2:0] entry_type;
    logic [7:0] entry_data;
    logic       is_release;
    logic [4:0] map_byte_index;
  } key_item_t;

  // One boot report as the block returns it
  typedef struct packed {
    logic [7:0]      mods;
    logic [5:0][7:0] slots;
    logic [7:0]      layer;
    logic [7:0]      map_byte;
  } report_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] action = '0;
  logic [7:0] key_id = '0;
  logic [2:0] entry_layer = '0;
  logic [2:0] entry_type = '0;
  logic [7:0] entry_data = '0;
  logic       is_release = 1'b0;
  logic [4:0] map_byte_index = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] modifier_bits;
  logic [7:0] slot0, slot1, slot2, slot3, slot4, slot5;
  logic [7:0] active_layer;
  logic [7:0] map_byte;

  layered_keymap_hid_report uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .key_id         (key_id),
    .entry_layer    (entry_layer),
    .entry_type     (entry_type),
    .entry_data     (entry_data),
    .is_release     (is_release),
    .map_byte_index (map_byte_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .modifier_bits  (modifier_bits),
    .slot0          (slot0),
    .slot1          (slot1),
    .slot2          (slot2),
    .slot3          (slot3),
    .slot4          (slot4),
    .slot5          (slot5),
    .active_layer   (active_layer),
    .map_byte       (map_byte)
  );

  always #5 clk = ~clk;

  // Shadow copy of the keyboard state, advanced once per accepted transaction
  logic [10:0]  keymap_model [N_LAYERS][N_KEYS] = '{default: '0};
  logic [255:0] pressed_model = '0;
  logic [7:0]   mods_model = '0;
  logic [7:0]   layer_model = '0;
  logic [7:0]   switch_model = '0;

  report_t report_q[$];     // boot reports still owed by the block
  logic [7:0] pool_keys [POOL_SIZE];

  int idle_pct = 0;         // chance in percent that the sender idles a cycle
  int stall_pct = 0;        // chance in percent that the receiver stalls a cycle
  int items_sent = 0;
  int reports_seen = 0;
  int mismatches = 0;
  int max_pressed = 0;
  int layer_visits = 0;

  // Apply one transaction to the shadow state and return the report it yields.
  function automatic report_t model_step(input key_item_t it);
    report_t    r;
    logic [10:0] ent;
    logic [2:0] ty;
    logic [7:0] dat;
    int         n;
    r = '0;
    case (it.action)
      lkh_pkg::ACT_WRITE: begin
        // Both index fields are always inside the table at the default sizes
        keymap_model[it.entry_layer][it.key_id] = {it.entry_type, it.entry_data};
      end
      lkh_pkg::ACT_KEY: begin
        // Key zero and a layer beyond the table find nothing
        if (it.key_id != 8'd0 && layer_model < N_LAYERS) begin
          ent = keymap_model[layer_model[2:0]][it.key_id];
          ty  = ent[10:8];
          dat = ent[7:0];
          if (ty != lkh_pkg::TYPE_NONE) begin
            if (switch_model == it.key_id && layer_model != 8'd0) begin
              // Only the release of the held switch key does anything: go home
              if (it.is_release) begin
                layer_model  = 8'd0;
                switch_model = 8'd0;
              end
            end else begin
              case (ty)
                lkh_pkg::TYPE_HID: pressed_model[dat] = !it.is_release;
                lkh_pkg::TYPE_MOD: begin
                  if (dat <= lkh_pkg::MOD_BIT_MAX) mods_model[dat[2:0]] = !it.is_release;
                end
                lkh_pkg::TYPE_SWITCH: begin
                  if (!it.is_release && layer_model == 8'd0) begin
                    layer_model  = dat;
                    switch_model = it.key_id;
                    if (dat != 8'd0) layer_visits++;
                  end
                end
                default: ;
              endcase
            end
          end
        end
      end
      lkh_pkg::ACT_READ: r.map_byte = pressed_model[{it.map_byte_index, 3'b000} +: 8];
      default: ;
    endcase
    r.mods  = mods_model;
    r.layer = layer_model;
    n = 0;
    for (int c = 0; c < 256; c++) begin
      if (pressed_model[c]) begin
        if (n < lkh_pkg::MAX_SLOTS) r.slots[n] = c[7:0];
        n++;
      end
    end
    if (n > max_pressed) max_pressed = n;
    return r;
  endfunction

  // Fill every field with noise; callers override the fields that matter.
  function automatic key_item_t random_item();
    key_item_t it;
    it.action         = 2'($urandom_range(0, 3));
    it.key_id         = 8'($urandom_range(0, 255));
    it.entry_layer    = 3'($urandom_range(0, 7));
    it.entry_type     = 3'($urandom_range(0, 7));
    it.entry_data     = 8'($urandom_range(0, 255));
    it.is_release     = 1'($urandom_range(0, 1));
    it.map_byte_index = 5'($urandom_range(0, 31));
    return it;
  endfunction

  // Drive one transaction and hold it until the block takes it.
  task automatic send_item(input key_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    action         <= it.action;
    key_id         <= it.key_id;
    entry_layer    <= it.entry_layer;
    entry_type     <= it.entry_type;
    entry_data     <= it.entry_data;
    is_release     <= it.is_release;
    map_byte_index <= it.map_byte_index;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    report_q.push_back(model_step(it));
    items_sent++;
  endtask

  task automatic write_entry(input logic [2:0] layer, input logic [7:0] key,
                             input logic [2:0] ty, input logic [7:0] data);
    key_item_t it;
    it             = random_item();
    it.action      = lkh_pkg::ACT_WRITE;
    it.entry_layer = layer;
    it.key_id      = key;
    it.entry_type  = ty;
    it.entry_data  = data;
    send_item(it);
  endtask

  task automatic key_event(input logic [7:0] key, input logic rel);
    key_item_t it;
    it            = random_item();
    it.action     = lkh_pkg::ACT_KEY;
    it.key_id     = key;
    it.is_release = rel;
    send_item(it);
  endtask

  task automatic read_byte(input logic [4:0] idx);
    key_item_t it;
    it                = random_item();
    it.action         = lkh_pkg::ACT_READ;
    it.map_byte_index = idx;
    send_item(it);
  endtask

  // Release the held switch key so the keyboard returns to layer 0.
  task automatic go_home();
    if (layer_model != 8'd0) key_event(switch_model, 1'b1);
  endtask

  // Pick a plausible entry. Never leave a nonzero layer empty at a pool key,
  // so the switch key that led there can always be released.
  task automatic random_entry(input logic [2:0] layer, output logic [2:0] ty,
                              output logic [7:0] data);
    int r;
    r    = $urandom_range(0, 99);
    data = 8'($urandom_range(0, 255));
    if (r < 50) begin
      ty = lkh_pkg::TYPE_HID;
    end else if (r < 70) begin
      ty = lkh_pkg::TYPE_MOD;
      if ($urandom_range(0, 9) != 0) data = 8'($urandom_range(0, 7));
    end else if (r < 85) begin
      ty   = lkh_pkg::TYPE_SWITCH;
      data = 8'($urandom_range(0, 7));
    end else if (r < 95 || layer != 3'd0) begin
      ty = 3'($urandom_range(TYPE_ACTION, TYPE_UNDEF));
    end else begin
      ty = lkh_pkg::TYPE_NONE;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall at random and check every report against the oldest one
  // owed. Sample on the rising edge so only pre-edge values are seen.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("report %0d: %s expected 0x%02h, got 0x%02h", reports_seen, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (report_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("report %0d: arrived with nothing expected", reports_seen);
      end else begin
        want = report_q.pop_front();
        check_field("modifier_bits", want.mods, modifier_bits);
        check_field("slot0", want.slots[0], slot0);
        check_field("slot1", want.slots[1], slot1);
        check_field("slot2", want.slots[2], slot2);
        check_field("slot3", want.slots[3], slot3);
        check_field("slot4", want.slots[4], slot4);
        check_field("slot5", want.slots[5], slot5);
        check_field("active_layer", want.layer, active_layer);
        check_field("map_byte", want.map_byte, map_byte);
      end
      reports_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Empty keyboard: the spare action with every field at its top value changes
  // nothing and still returns an all-zero report.
  task automatic test_idle_report();
    key_item_t it;
    it                = '1;
    it.action         = ACT_UNUSED;
    send_item(it);
    read_byte(5'd0);
  endtask

  // HID codes at both ends of the range; a write at key zero lands in the
  // table but key zero is never looked up.
  task automatic test_hid_codes();
    write_entry(3'd0, 8'd255, lkh_pkg::TYPE_HID, 8'hFF);
    write_entry(3'd0, 8'd1, lkh_pkg::TYPE_HID, 8'h04);
    write_entry(3'd0, 8'd0, lkh_pkg::TYPE_HID, 8'h05);
    key_event(8'd255, 1'b0);
    key_event(8'd1, 1'b0);
    key_event(8'd0, 1'b0);
    read_byte(5'd31);
    read_byte(5'd0);
  endtask

  // Top modifier bit sets and clears; an index above seven is dropped.
  task automatic test_modifiers();
    write_entry(3'd0, 8'd2, lkh_pkg::TYPE_MOD, 8'd7);
    write_entry(3'd0, 8'd3, lkh_pkg::TYPE_MOD, 8'd8);
    key_event(8'd2, 1'b0);
    key_event(8'd3, 1'b0);
    key_event(8'd2, 1'b1);
  endtask

  // Layer switching: no-op entry types, empty entries, the held switch key,
  // and a second switch attempted off layer 0.
  task automatic test_layer_switch();
    write_entry(3'd0, 8'd4, lkh_pkg::TYPE_SWITCH, 8'd5);
    write_entry(3'd5, 8'd4, TYPE_ACTION, 8'h5A);
    write_entry(3'd5, 8'd1, TYPE_UNDEF, 8'hA5);
    write_entry(3'd5, 8'd6, lkh_pkg::TYPE_SWITCH, 8'd2);
    key_event(8'd4, 1'b0);   // enter layer 5
    key_event(8'd1, 1'b0);   // undefined type: nothing
    key_event(8'd9, 1'b0);   // empty entry: nothing
    key_event(8'd6, 1'b0);   // switch off layer 0: dropped
    key_event(8'd4, 1'b0);   // held switch key pressed again: nothing
    key_event(8'd4, 1'b1);   // release: back to layer 0
    key_event(8'd255, 1'b1);
  endtask

  // Map every pool key on every layer so random keystrokes reach real entries.
  task automatic test_random_keymap_fill();
    logic [2:0] ty;
    logic [7:0] data;
    for (int k = 0; k < POOL_SIZE; k++) pool_keys[k] = 8'($urandom_range(1, 255));
    for (int l = 0; l < N_LAYERS; l++) begin
      for (int k = 0; k < POOL_SIZE; k++) begin
        random_entry(l[2:0], ty, data);
        write_entry(l[2:0], pool_keys[k], ty, data);
      end
    end
  endtask

  // Mostly keystrokes on mapped keys, plus rewrites, map reads and noise.
  task automatic test_random_traffic(input int count, input int idle, input int stall);
    key_item_t  it;
    logic [2:0] layer;
    logic [2:0] ty;
    logic [7:0] data;
    int         r;
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        layer = 3'($urandom_range(0, 7));
        random_entry(layer, ty, data);
        write_entry(layer, pool_keys[4'($urandom_range(0, POOL_SIZE - 1))], ty, data);
      end else if (r < 75) begin
        if (layer_model != 8'd0 && $urandom_range(0, 9) == 0)
          go_home();
        else if ($urandom_range(0, 19) == 0)
          key_event(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        else
          key_event(pool_keys[4'($urandom_range(0, POOL_SIZE - 1))],
                    1'($urandom_range(0, 1)));
      end else if (r < 95) begin
        read_byte(5'($urandom_range(0, 31)));
      end else begin
        it        = random_item();
        it.action = ACT_UNUSED;
        send_item(it);
      end
    end
  endtask

  // A switch to a layer beyond the table: every lookup finds nothing from then
  // on, the switch key's release included, so run this last.
  task automatic test_layer_out_of_range();
    idle_pct  = 33;
    stall_pct = 33;
    go_home();
    write_entry(3'd0, 8'd7, lkh_pkg::TYPE_SWITCH, 8'hC8);
    key_event(8'd7, 1'b0);
    key_event(8'd1, 1'b0);
    key_event(8'd7, 1'b1);
    read_byte(5'd31);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // The block sweeps its keymap after reset; the first send simply waits.
    test_idle_report();
    test_hid_codes();
    test_modifiers();
    test_layer_switch();

    test_random_keymap_fill();
    test_random_traffic(250, 0, 0);
    test_random_traffic(250, 79, 0);
    test_random_traffic(250, 0, 79);
    test_random_traffic(250, 33, 33);

    test_layer_out_of_range();

    // Drop valid, let every owed report arrive, then watch for strays.
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Sent %0d transactions and checked %0d reports; %0d mismatches.",
             items_sent, reports_seen, mismatches);
    $display("Up to %0d codes held at once, %0d entries into nonzero layers.",
             max_pressed, layer_visits);
    if (mismatches == 0) begin
      $display("layered_keymap_hid_report verification clean");
    end else begin
      $display("layered_keymap_hid_report verification failed");
    end
    $finish;
  end

  // Hard stop if the handshake hangs
  initial begin
    #10_000_000;
    $display("layered_keymap_hid_report verification failed");
    $finish;
  end

endmodule

@@ layered_keymap_hid_report.f @@
hw/rtl/lkh_pkg.sv
hw/rtl/lkh_keymap_ram.sv
hw/rtl/lkh_scan.sv
hw/rtl/layered_keymap_hid_report.sv
tb/layered_keymap_hid_report_tb.sv
